// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file dpct_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked only while reset is released.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/dpct_pkg.sv =====
package dpct_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_BITS = 32;
    localparam int TIME_BITS = 31;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Squared terms carry two fraction fields.
    localparam int SQ_BITS = 2 * IN_BITS;
    localparam int D_BITS = 2 * SQ_BITS;
    localparam int ROOT_BITS = D_BITS / 2;

    typedef struct packed {
        logic                 hit;
        logic [TIME_BITS-1:0] contact_time;
        logic                 overflow;
    } t_result;

endpackage

// ===== design/dpct_sqrt_div.sv =====
module dpct_sqrt_div
    import dpct_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic                 i_cand,
    input  logic [D_BITS-1:0]    i_d,
    input  logic [SQ_BITS-1:0]   i_b,
    input  logic [SQ_BITS-1:0]   i_a,
    input  logic [TIME_BITS-1:0] i_t0,
    output logic                 o_valid,
    output t_result              o_res
);

    localparam int RS = ROOT_BITS;
    localparam int RW = RS + 2;
    localparam int NQ = SQ_BITS + FRAC_BITS;

    // Root stages: one result bit per stage, two radicand bits consumed per stage.
    logic [RS:0]                 r_sv;
    logic [RS:0]                 r_sc;
    logic [RS:0][D_BITS-1:0]     r_sd;
    logic [RS:0][RW-1:0]         r_sm;
    logic [RS:0][RS-1:0]         r_sr;
    logic [RS:0][SQ_BITS-1:0]    r_sb;
    logic [RS:0][SQ_BITS-1:0]    r_sa;
    logic [RS:0][TIME_BITS-1:0]  r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (i_adv) begin
            r_sv <= {r_sv[RS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sc[0] <= i_cand;
            r_sd[0] <= i_d;
            r_sm[0] <= '0;
            r_sr[0] <= '0;
            r_sb[0] <= i_b;
            r_sa[0] <= i_a;
            r_st[0] <= i_t0;
            for (int k = 0; k < RS; k++) begin
                logic [RW+1:0] t;
                logic [RW+1:0] tr;
                t = {r_sm[k], r_sd[k][D_BITS-1 -: 2]};
                tr = {2'b00, r_sr[k], 2'b01};
                if (t >= tr) begin
                    r_sm[k+1] <= RW'(t - tr);
                    r_sr[k+1] <= {r_sr[k][RS-2:0], 1'b1};
                end else begin
                    r_sm[k+1] <= RW'(t);
                    r_sr[k+1] <= {r_sr[k][RS-2:0], 1'b0};
                end
                r_sd[k+1] <= {r_sd[k][D_BITS-3:0], 2'b00};
                r_sc[k+1] <= r_sc[k];
                r_sb[k+1] <= r_sb[k];
                r_sa[k+1] <= r_sa[k];
                r_st[k+1] <= r_st[k];
            end
        end
    end

    // Divider stages: restoring, one quotient bit per stage.
    logic [NQ:0]                r_qv;
    logic [NQ:0]                r_qc;
    logic [NQ:0][NQ-1:0]        r_qn;
    logic [NQ:0][SQ_BITS:0]     r_qr;
    logic [NQ:0][NQ-1:0]        r_qq;
    logic [NQ:0][SQ_BITS-1:0]   r_qa;
    logic [NQ:0][TIME_BITS-1:0] r_qt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
        end else if (i_adv) begin
            r_qv <= {r_qv[NQ-1:0], r_sv[RS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_qc[0] <= r_sc[RS];
            r_qn[0] <= {r_sb[RS] - SQ_BITS'(r_sr[RS]), {FRAC_BITS{1'b0}}};
            r_qr[0] <= '0;
            r_qq[0] <= '0;
            r_qa[0] <= r_sa[RS];
            r_qt[0] <= r_st[RS];
            for (int k = 0; k < NQ; k++) begin
                logic [SQ_BITS+1:0] rm;
                rm = {r_qr[k], r_qn[k][NQ-1]};
                if (rm >= (SQ_BITS+2)'(r_qa[k])) begin
                    r_qr[k+1] <= (SQ_BITS+1)'(rm - (SQ_BITS+2)'(r_qa[k]));
                    r_qq[k+1] <= {r_qq[k][NQ-2:0], 1'b1};
                end else begin
                    r_qr[k+1] <= (SQ_BITS+1)'(rm);
                    r_qq[k+1] <= {r_qq[k][NQ-2:0], 1'b0};
                end
                r_qn[k+1] <= {r_qn[k][NQ-2:0], 1'b0};
                r_qc[k+1] <= r_qc[k];
                r_qa[k+1] <= r_qa[k];
                r_qt[k+1] <= r_qt[k];
            end
        end
    end

    logic [NQ-1:0]  q;
    logic [NQ:0]    sum;
    assign q = r_qq[NQ];
    assign sum = (NQ+1)'(r_qt[NQ]) + (NQ+1)'(q);

    always_comb begin
        o_valid = r_qv[NQ];
        o_res.hit = r_qc[NQ];
        o_res.overflow = 1'b0;
        o_res.contact_time = TIME_MAX;
        if (r_qc[NQ]) begin
            if (sum > (NQ+1)'(TIME_MAX)) begin
                o_res.overflow = 1'b1;
            end else begin
                o_res.contact_time = sum[TIME_BITS-1:0];
            end
        end
    end

endmodule

// ===== design/disk_pair_collision_time.sv =====
// Pipelined disk pair contact time predictor.
// An input beat passes through the arithmetic stages, the root stages, the divider stages and the output register.
// Throughput: one beat per cycle while not stalled; the root and divide run one bit per stage.
// A stall freezes the whole pipeline when the output register holds a beat.
// Synchronous active-low reset clears all valid bits; payload is not reset.
module disk_pair_collision_time
    import dpct_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [IN_BITS-1:0]   i_first_pos_x,
    input  logic signed [IN_BITS-1:0]   i_first_pos_y,
    input  logic signed [IN_BITS-1:0]   i_first_vel_x,
    input  logic signed [IN_BITS-1:0]   i_first_vel_y,
    input  logic [TIME_BITS-1:0]        i_first_stamp,
    input  logic [TIME_BITS-1:0]        i_first_radius,
    input  logic signed [IN_BITS-1:0]   i_second_pos_x,
    input  logic signed [IN_BITS-1:0]   i_second_pos_y,
    input  logic signed [IN_BITS-1:0]   i_second_vel_x,
    input  logic signed [IN_BITS-1:0]   i_second_vel_y,
    input  logic [TIME_BITS-1:0]        i_second_stamp,
    input  logic [TIME_BITS-1:0]        i_second_radius,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit,
    output logic [TIME_BITS-1:0]        o_contact_time,
    output logic                        o_overflow
);

    localparam int SAT = (WORD_BITS < IN_BITS) ? WORD_BITS : IN_BITS;
    localparam int PB = 2 * IN_BITS + 2;
    localparam int XB = PB;
    localparam int H = SQ_BITS / 2;

    logic adv;
    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;

    function automatic logic signed [IN_BITS-1:0] sat_w(input logic signed [XB-1:0] v);
        logic signed [XB-1:0] mx;
        mx = XB'((64'sd1 <<< (SAT - 1)) - 1);
        if (v > mx) return IN_BITS'(mx);
        if (v < -mx - 1) return IN_BITS'(-mx - 1);
        return IN_BITS'(v);
    endfunction

    // Stage 1: pick the older disk, form stamp difference, velocity difference, velocity products and radius sum.
    logic r_v1;
    logic signed [IN_BITS-1:0] r1_pa_x, r1_pa_y, r1_pb_x, r1_pb_y;
    logic signed [IN_BITS-1:0] r1_dvx, r1_dvy;
    logic signed [PB-1:0] r1_mx, r1_my;
    logic [TIME_BITS-1:0] r1_t0;
    logic [TIME_BITS:0] r1_len;
    logic n_swap;
    logic [TIME_BITS-1:0] n_dt;
    logic signed [IN_BITS-1:0] n_mvx, n_mvy;

    always_comb begin
        n_swap = i_first_stamp > i_second_stamp;
        n_dt = n_swap ? i_first_stamp - i_second_stamp : i_second_stamp - i_first_stamp;
        n_mvx = n_swap ? i_second_vel_x : i_first_vel_x;
        n_mvy = n_swap ? i_second_vel_y : i_first_vel_y;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_pa_x <= n_swap ? i_first_pos_x : i_second_pos_x;
            r1_pa_y <= n_swap ? i_first_pos_y : i_second_pos_y;
            r1_pb_x <= n_swap ? i_second_pos_x : i_first_pos_x;
            r1_pb_y <= n_swap ? i_second_pos_y : i_first_pos_y;
            r1_dvx <= sat_w(n_swap ? XB'(i_first_vel_x) - XB'(i_second_vel_x)
                                   : XB'(i_second_vel_x) - XB'(i_first_vel_x));
            r1_dvy <= sat_w(n_swap ? XB'(i_first_vel_y) - XB'(i_second_vel_y)
                                   : XB'(i_second_vel_y) - XB'(i_first_vel_y));
            r1_mx <= $signed({1'b0, n_dt}) * PB'(n_mvx);
            r1_my <= $signed({1'b0, n_dt}) * PB'(n_mvy);
            r1_t0 <= n_swap ? i_first_stamp : i_second_stamp;
            r1_len <= {1'b0, i_first_radius} + {1'b0, i_second_radius};
        end
    end

    // Stage 2: floor shift, relative position.
    logic r_v2;
    logic signed [IN_BITS-1:0] r2_drx, r2_dry, r2_dvx, r2_dvy;
    logic [TIME_BITS:0] r2_len;
    logic [TIME_BITS-1:0] r2_t0;
    logic signed [PB-1:0] n_sx, n_sy;

    assign n_sx = r1_mx >>> FRAC_BITS;
    assign n_sy = r1_my >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_drx <= sat_w(XB'(r1_pa_x) - XB'(r1_pb_x) - XB'(n_sx));
            r2_dry <= sat_w(XB'(r1_pa_y) - XB'(r1_pb_y) - XB'(n_sy));
            r2_dvx <= r1_dvx;
            r2_dvy <= r1_dvy;
            r2_len <= r1_len;
            r2_t0 <= r1_t0;
        end
    end

    // Stage 3: products.
    logic r_v3;
    logic signed [PB-1:0] r3_axx, r3_ayy, r3_rxx, r3_ryy, r3_px, r3_py;
    logic [PB-1:0] r3_l2;
    logic [TIME_BITS-1:0] r3_t0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_axx <= PB'(r2_dvx) * PB'(r2_dvx);
            r3_ayy <= PB'(r2_dvy) * PB'(r2_dvy);
            r3_rxx <= PB'(r2_drx) * PB'(r2_drx);
            r3_ryy <= PB'(r2_dry) * PB'(r2_dry);
            r3_px <= PB'(r2_drx) * PB'(r2_dvx);
            r3_py <= PB'(r2_dry) * PB'(r2_dvy);
            r3_l2 <= PB'(r2_len) * PB'(r2_len);
            r3_t0 <= r2_t0;
        end
    end

    // Stage 4: A, B, C and the candidate condition.
    logic r_v4, r4_ok;
    logic [SQ_BITS-1:0] r4_a, r4_b, r4_c;
    logic [TIME_BITS-1:0] r4_t0;
    logic signed [PB-1:0] n_b;
    logic [PB-1:0] n_a, n_m;

    always_comb begin
        n_a = PB'(r3_axx + r3_ayy);
        n_m = PB'(r3_rxx + r3_ryy);
        n_b = -r3_px - r3_py;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_ok <= (n_a != '0) && (n_b > 0) && (n_m > r3_l2);
            r4_a <= SQ_BITS'(n_a);
            r4_b <= SQ_BITS'(n_b);
            r4_c <= SQ_BITS'(n_m - r3_l2);
            r4_t0 <= r3_t0;
        end
    end

    // Stage 5: half-word partial products of B*B and A*C.
    logic r_v5, r5_ok;
    logic [SQ_BITS-1:0] r5_bhh, r5_bhl, r5_bll, r5_ahh, r5_ahl, r5_alh, r5_all;
    logic [SQ_BITS-1:0] r5_a, r5_b;
    logic [TIME_BITS-1:0] r5_t0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_bhh <= SQ_BITS'(r4_b[SQ_BITS-1:H]) * SQ_BITS'(r4_b[SQ_BITS-1:H]);
            r5_bhl <= SQ_BITS'(r4_b[SQ_BITS-1:H]) * SQ_BITS'(r4_b[H-1:0]);
            r5_bll <= SQ_BITS'(r4_b[H-1:0]) * SQ_BITS'(r4_b[H-1:0]);
            r5_ahh <= SQ_BITS'(r4_a[SQ_BITS-1:H]) * SQ_BITS'(r4_c[SQ_BITS-1:H]);
            r5_ahl <= SQ_BITS'(r4_a[SQ_BITS-1:H]) * SQ_BITS'(r4_c[H-1:0]);
            r5_alh <= SQ_BITS'(r4_a[H-1:0]) * SQ_BITS'(r4_c[SQ_BITS-1:H]);
            r5_all <= SQ_BITS'(r4_a[H-1:0]) * SQ_BITS'(r4_c[H-1:0]);
            r5_ok <= r4_ok;
            r5_a <= r4_a;
            r5_b <= r4_b;
            r5_t0 <= r4_t0;
        end
    end

    // Stage 6: discriminant terms.
    logic r_v6, r6_ok;
    logic [D_BITS-1:0] r6_b2, r6_ac;
    logic [SQ_BITS-1:0] r6_a, r6_b;
    logic [TIME_BITS-1:0] r6_t0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_b2 <= {r5_bhh, r5_bll} + (D_BITS'(r5_bhl) << (H + 1));
            r6_ac <= {r5_ahh, r5_all} + (D_BITS'(r5_ahl) << H) + (D_BITS'(r5_alh) << H);
            r6_ok <= r5_ok;
            r6_a <= r5_a;
            r6_b <= r5_b;
            r6_t0 <= r5_t0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6} <= '0;
        end else if (adv) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6} <= {i_valid, r_v1, r_v2, r_v3, r_v4, r_v5};
        end
    end

    logic n_cand;
    logic [D_BITS-1:0] n_d;
    assign n_cand = r6_ok && (r6_b2 > r6_ac);
    assign n_d = n_cand ? r6_b2 - r6_ac : '0;

    t_result res;
    logic    res_v;

    dpct_sqrt_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sqrt_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_v6),
        .i_cand  (n_cand),
        .i_d     (n_d),
        .i_b     (r6_b),
        .i_a     (n_cand ? r6_a : SQ_BITS'(1)),
        .i_t0    (r6_t0),
        .o_valid (res_v),
        .o_res   (res)
    );

    logic r_ov;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_valid = r_ov;
    assign o_hit = r_out.hit;
    assign o_contact_time = r_out.contact_time;
    assign o_overflow = r_out.overflow;

endmodule

// ===== design/dpct_checker.sv =====
`include "assert_macros.svh"

module dpct_checker
    import dpct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic                 o_stall,
    input  logic                 o_hit,
    input  logic [TIME_BITS-1:0] o_contact_time,
    input  logic                 o_overflow
);

    `CHK_ASSERT(a_nohit_max, i_clk, i_rst_n, o_valid && !o_hit |-> o_contact_time == TIME_MAX && !o_overflow, "no-hit beat must carry maximum time")
    `CHK_ASSERT(a_ovf_max, i_clk, i_rst_n, o_valid && o_overflow |-> o_contact_time == TIME_MAX, "overflow must saturate")
    `CHK_ASSERT(a_stall_src, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "stall only from a held output")
    `CHK_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_contact_time), "stalled beat must hold")

endmodule

bind disk_pair_collision_time dpct_checker u_dpct_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_stall        (o_stall),
    .o_hit          (o_hit),
    .o_contact_time (o_contact_time),
    .o_overflow     (o_overflow)
);
